>>> rtl/core/rrp_pkg.sv
// rrp_pkg: shared types, constants and helpers for the rounded rectangle path block
// no dependencies; used by the channel interfaces, the top level and the checker
package rrp_pkg;

  localparam int unsigned CoordW = 32;
  // widest exact sum is x + w - r +/- k, which needs a few guard bits
  localparam int unsigned SumW = 36;
  // circle constant 0.5522847498307936 as unsigned Q0.32
  localparam logic [31:0] KappaQ32 = 32'd2372044939;
  localparam logic [63:0] KappaRound = 64'h0000_0000_8000_0000;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [SumW-1:0]   sum_t;

  typedef enum logic [2:0] {
    CMD_MOVE   = 3'd0,
    CMD_LINE   = 3'd1,
    CMD_CURVE  = 3'd2,
    CMD_CLOSE  = 3'd3,
    CMD_REJECT = 3'd4
  } cmd_e;

  // raw rectangle request
  typedef struct packed {
    coord_t rect_x;
    coord_t rect_y;
    coord_t rect_width;
    coord_t rect_height;
    coord_t radius_x;
    coord_t radius_y;
    logic   radius_x_given;
    logic   radius_y_given;
  } rect_t;

  // after radius selection and clamping
  typedef struct packed {
    logic   rej;
    logic   plain;
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
    coord_t rx;
    coord_t ry;
  } shape_t;

  // edge coordinates and control offsets used by the command sequencer
  typedef struct packed {
    logic rej;
    logic plain;
    sum_t x;
    sum_t xr;
    sum_t xw;
    sum_t xwr;
    sum_t y;
    sum_t yr;
    sum_t yh;
    sum_t yhr;
    sum_t kx;
    sum_t ky;
  } edges_t;

  function automatic sum_t ext_coord(coord_t v);
    return sum_t'(v);
  endfunction

  function automatic coord_t sat_coord(sum_t v);
    coord_t r;
    if ((&v[SumW-1:CoordW-1]) || !(|v[SumW-1:CoordW-1])) begin
      r = v[CoordW-1:0];
    end else if (v[SumW-1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/rrp_rect_if.sv
// rrp_rect_if: valid/ready channel that carries one rectangle request
// depends on rrp_pkg
interface rrp_rect_if;
  import rrp_pkg::*;

  logic   valid;
  logic   ready;
  coord_t rect_x;
  coord_t rect_y;
  coord_t rect_width;
  coord_t rect_height;
  coord_t radius_x;
  coord_t radius_y;
  logic   radius_x_given;
  logic   radius_y_given;

  modport source (
    output valid, rect_x, rect_y, rect_width, rect_height,
           radius_x, radius_y, radius_x_given, radius_y_given,
    input  ready
  );

  modport sink (
    input  valid, rect_x, rect_y, rect_width, rect_height,
           radius_x, radius_y, radius_x_given, radius_y_given,
    output ready
  );

endinterface

>>> rtl/core/rrp_path_if.sv
// rrp_path_if: valid/ready channel that carries one path command
// depends on rrp_pkg
interface rrp_path_if;
  import rrp_pkg::*;

  logic   valid;
  logic   ready;
  cmd_e   command;
  coord_t ctrl1_x;
  coord_t ctrl1_y;
  coord_t ctrl2_x;
  coord_t ctrl2_y;
  coord_t end_x;
  coord_t end_y;
  logic   last;

  modport source (
    output valid, command, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y, last,
    input  ready
  );

  modport sink (
    input  valid, command, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y, last,
    output ready
  );

endinterface

>>> rtl/core/rounded_rect_to_path.sv
// rounded_rect_to_path: throughput is one command per cycle while path_o is ready;
// a rounded rectangle gives 10 commands, a plain one 5, a rejected one 1. the
// single-command output register sets that rate; the three front stages keep the
// next rectangle moving while the current one is emitted.
// reset: asynchronous active low, empties every stage; no request is in flight after it.
// depends on rrp_pkg, rrp_rect_if, rrp_path_if
module rounded_rect_to_path (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrp_rect_if.sink    rect_i,
  rrp_path_if.source  path_o
);
  import rrp_pkg::*;

  // stage 1: raw request
  logic   s1_v_q;
  rect_t  s1_q;
  // stage 2: selected and clamped radii
  logic   s2_v_q;
  shape_t s2_q, s2_d;
  // stage 3: sequencer holding edges and offsets
  logic   em_v_q;
  edges_t em_q, em_d;
  logic [3:0] step_q;
  // output register
  logic   o_v_q;
  cmd_e   o_cmd_q;
  coord_t o_c1x_q, o_c1y_q, o_c2x_q, o_c2y_q, o_ex_q, o_ey_q;
  logic   o_last_q;

  logic   o_free, em_emit, em_free, em_load, s2_free, s1_load, s2_load;

  cmd_e   cmd_d;
  coord_t c1x_d, c1y_d, c2x_d, c2y_d, ex_d, ey_d;
  logic   last_d;

  // ---------------- flow control ----------------
  assign o_free  = !o_v_q || path_o.ready;
  assign em_emit = em_v_q && o_free;
  assign em_free = !em_v_q || (em_emit && last_d);
  assign em_load = s2_v_q && em_free;
  assign s2_free = !s2_v_q || em_free;
  assign s2_load = s1_v_q && s2_free;
  assign s1_load = rect_i.valid && rect_i.ready;
  assign rect_i.ready = !s1_v_q || s2_free;

  // ---------------- stage 1 -> 2: radius select and clamp ----------------
  always_comb begin
    coord_t rx_sel, ry_sel, half_w, half_h, rx_c, ry_c;
    if (s1_q.radius_x_given) begin
      rx_sel = s1_q.radius_x;
    end else if (s1_q.radius_y_given) begin
      rx_sel = s1_q.radius_y;
    end else begin
      rx_sel = '0;
    end
    if (s1_q.radius_y_given) begin
      ry_sel = s1_q.radius_y;
    end else if (s1_q.radius_x_given) begin
      ry_sel = s1_q.radius_x;
    end else begin
      ry_sel = '0;
    end
    half_w = s1_q.rect_width >>> 1;
    half_h = s1_q.rect_height >>> 1;
    rx_c   = (rx_sel > half_w) ? half_w : rx_sel;
    ry_c   = (ry_sel > half_h) ? half_h : ry_sel;

    s2_d.rej   = (s1_q.rect_width <= 0) || (s1_q.rect_height <= 0);
    s2_d.plain = (rx_c <= 0) || (ry_c <= 0);
    s2_d.x     = s1_q.rect_x;
    s2_d.y     = s1_q.rect_y;
    s2_d.w     = s1_q.rect_width;
    s2_d.h     = s1_q.rect_height;
    // a plain rectangle runs with zero radii so its corners fall on the edges
    s2_d.rx    = s2_d.plain ? '0 : rx_c;
    s2_d.ry    = s2_d.plain ? '0 : ry_c;
  end

  // ---------------- stage 2 -> 3: kappa offsets and edge sums ----------------
  always_comb begin
    logic [63:0] kx_p, ky_p;
    sum_t x, y, w, h, rx, ry;
    x  = ext_coord(s2_q.x);
    y  = ext_coord(s2_q.y);
    w  = ext_coord(s2_q.w);
    h  = ext_coord(s2_q.h);
    rx = ext_coord(s2_q.rx);
    ry = ext_coord(s2_q.ry);
    // radii are non-negative and below 2^30 here
    kx_p = 64'(s2_q.rx[CoordW-2:0]) * 64'(KappaQ32) + KappaRound;
    ky_p = 64'(s2_q.ry[CoordW-2:0]) * 64'(KappaQ32) + KappaRound;

    em_d.rej   = s2_q.rej;
    em_d.plain = s2_q.plain;
    em_d.x     = x;
    em_d.xr    = x + rx;
    em_d.xw    = x + w;
    em_d.xwr   = x + w - rx;
    em_d.y     = y;
    em_d.yr    = y + ry;
    em_d.yh    = y + h;
    em_d.yhr   = y + h - ry;
    em_d.kx    = sum_t'(kx_p[63:32]);
    em_d.ky    = sum_t'(ky_p[63:32]);
  end

  // ---------------- stage 3: command sequencer ----------------
  always_comb begin
    sum_t xwrk, xrk, yrk, yhrk;
    xwrk = em_q.xwr + em_q.kx;
    xrk  = em_q.xr - em_q.kx;
    yrk  = em_q.yr - em_q.ky;
    yhrk = em_q.yhr + em_q.ky;
    cmd_d  = CMD_CLOSE;
    c1x_d  = '0;
    c1y_d  = '0;
    c2x_d  = '0;
    c2y_d  = '0;
    ex_d   = '0;
    ey_d   = '0;
    last_d = 1'b0;
    if (em_q.rej) begin
      cmd_d  = CMD_REJECT;
      last_d = 1'b1;
    end else if (em_q.plain) begin
      case (step_q)
        4'd0: begin
          cmd_d = CMD_MOVE;
          ex_d  = sat_coord(em_q.x);
          ey_d  = sat_coord(em_q.y);
        end
        4'd1: begin
          cmd_d = CMD_LINE;
          ex_d  = sat_coord(em_q.xw);
          ey_d  = sat_coord(em_q.y);
        end
        4'd2: begin
          cmd_d = CMD_LINE;
          ex_d  = sat_coord(em_q.xw);
          ey_d  = sat_coord(em_q.yh);
        end
        4'd3: begin
          cmd_d = CMD_LINE;
          ex_d  = sat_coord(em_q.x);
          ey_d  = sat_coord(em_q.yh);
        end
        default: begin
          cmd_d  = CMD_CLOSE;
          last_d = 1'b1;
        end
      endcase
    end else begin
      case (step_q)
        4'd0: begin
          cmd_d = CMD_MOVE;
          ex_d  = sat_coord(em_q.xr);
          ey_d  = sat_coord(em_q.y);
        end
        4'd1: begin
          cmd_d = CMD_LINE;
          ex_d  = sat_coord(em_q.xwr);
          ey_d  = sat_coord(em_q.y);
        end
        4'd2: begin
          cmd_d = CMD_CURVE;
          c1x_d = sat_coord(xwrk);
          c1y_d = sat_coord(em_q.y);
          c2x_d = sat_coord(em_q.xw);
          c2y_d = sat_coord(yrk);
          ex_d  = sat_coord(em_q.xw);
          ey_d  = sat_coord(em_q.yr);
        end
        4'd3: begin
          cmd_d = CMD_LINE;
          ex_d  = sat_coord(em_q.xw);
          ey_d  = sat_coord(em_q.yhr);
        end
        4'd4: begin
          cmd_d = CMD_CURVE;
          c1x_d = sat_coord(em_q.xw);
          c1y_d = sat_coord(yhrk);
          c2x_d = sat_coord(xwrk);
          c2y_d = sat_coord(em_q.yh);
          ex_d  = sat_coord(em_q.xwr);
          ey_d  = sat_coord(em_q.yh);
        end
        4'd5: begin
          cmd_d = CMD_LINE;
          ex_d  = sat_coord(em_q.xr);
          ey_d  = sat_coord(em_q.yh);
        end
        4'd6: begin
          cmd_d = CMD_CURVE;
          c1x_d = sat_coord(xrk);
          c1y_d = sat_coord(em_q.yh);
          c2x_d = sat_coord(em_q.x);
          c2y_d = sat_coord(yhrk);
          ex_d  = sat_coord(em_q.x);
          ey_d  = sat_coord(em_q.yhr);
        end
        4'd7: begin
          cmd_d = CMD_LINE;
          ex_d  = sat_coord(em_q.x);
          ey_d  = sat_coord(em_q.yr);
        end
        4'd8: begin
          cmd_d = CMD_CURVE;
          c1x_d = sat_coord(em_q.x);
          c1y_d = sat_coord(yrk);
          c2x_d = sat_coord(xrk);
          c2y_d = sat_coord(em_q.y);
          ex_d  = sat_coord(em_q.xr);
          ey_d  = sat_coord(em_q.y);
        end
        default: begin
          cmd_d  = CMD_CLOSE;
          last_d = 1'b1;
        end
      endcase
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      em_v_q <= 1'b0;
      step_q <= '0;
      o_v_q  <= 1'b0;
    end else begin
      s1_v_q <= s1_load || (s1_v_q && !s2_load);
      s2_v_q <= s2_load || (s2_v_q && !em_load);
      em_v_q <= em_load || (em_v_q && !(em_emit && last_d));
      if (em_load) begin
        step_q <= '0;
      end else if (em_emit) begin
        step_q <= step_q + 4'd1;
      end
      o_v_q  <= em_emit || (o_v_q && !path_o.ready);
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q.rect_x         <= rect_i.rect_x;
      s1_q.rect_y         <= rect_i.rect_y;
      s1_q.rect_width     <= rect_i.rect_width;
      s1_q.rect_height    <= rect_i.rect_height;
      s1_q.radius_x       <= rect_i.radius_x;
      s1_q.radius_y       <= rect_i.radius_y;
      s1_q.radius_x_given <= rect_i.radius_x_given;
      s1_q.radius_y_given <= rect_i.radius_y_given;
    end
    if (s2_load) begin
      s2_q <= s2_d;
    end
    if (em_load) begin
      em_q <= em_d;
    end
    if (em_emit) begin
      o_cmd_q  <= cmd_d;
      o_c1x_q  <= c1x_d;
      o_c1y_q  <= c1y_d;
      o_c2x_q  <= c2x_d;
      o_c2y_q  <= c2y_d;
      o_ex_q   <= ex_d;
      o_ey_q   <= ey_d;
      o_last_q <= last_d;
    end
  end

  assign path_o.valid   = o_v_q;
  assign path_o.command = o_cmd_q;
  assign path_o.ctrl1_x = o_c1x_q;
  assign path_o.ctrl1_y = o_c1y_q;
  assign path_o.ctrl2_x = o_c2x_q;
  assign path_o.ctrl2_y = o_c2y_q;
  assign path_o.end_x   = o_ex_q;
  assign path_o.end_y   = o_ey_q;
  assign path_o.last    = o_last_q;

endmodule

>>> rtl/core/rrp_checker.sv
// rrp_checker: port-level assertions on the rounded rectangle path block
// depends on rrp_pkg; bound to rounded_rect_to_path at the end of this file
module rrp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input rrp_pkg::cmd_e out_command_i,
  input rrp_pkg::coord_t out_end_x_i,
  input rrp_pkg::coord_t out_end_y_i,
  input logic          out_last_i
);
  import rrp_pkg::*;

  // a stalled command keeps its content
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_command_i)
      && $stable(out_last_i) && $stable(out_end_x_i) && $stable(out_end_y_i))
    else $error("path command changed while stalled");

  // reject and close end a rectangle, with no end point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_command_i == CMD_REJECT || out_command_i == CMD_CLOSE)
      |-> out_last_i && out_end_x_i == '0 && out_end_y_i == '0)
    else $error("reject or close without last or with nonzero end point");

  // move, line and curve never end a rectangle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_command_i == CMD_MOVE || out_command_i == CMD_LINE
      || out_command_i == CMD_CURVE) |-> !out_last_i)
    else $error("drawing command flagged as last");

  // after the last command of a rectangle is taken, the next one opens with move or reject
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i ##1 out_valid_i
      |-> out_command_i == CMD_MOVE || out_command_i == CMD_REJECT)
    else $error("rectangle does not open with move or reject");

endmodule

bind rounded_rect_to_path rrp_checker u_rrp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (path_o.valid),
  .out_ready_i   (path_o.ready),
  .out_command_i (path_o.command),
  .out_end_x_i   (path_o.end_x),
  .out_end_y_i   (path_o.end_y),
  .out_last_i    (path_o.last)
);

>>> sim/tb_top.sv
// tb_top: self-checking bench for rounded_rect_to_path, drives rectangle requests and
// checks every path command against an internal predictor of the expected path
// depends on rrp_pkg, rrp_rect_if, rrp_path_if and the rounded_rect_to_path rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrp_pkg::*;

  localparam longint CoordHi = 64'sd2147483647;
  localparam longint CoordLo = -64'sd2147483648;
  localparam longint unsigned KappaScale = 64'd2372044939;
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles = 20;
  localparam coord_t Q1 = 32'sh0001_0000;
  localparam coord_t MaxC = 32'sh7fff_ffff;
  localparam coord_t MinC = 32'sh8000_0000;

  typedef struct {
    cmd_e   command;
    coord_t pt [6];
    logic   last;
  } path_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rrp_rect_if rect_bus ();
  rrp_path_if path_bus ();

  rounded_rect_to_path u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rect_i (rect_bus),
    .path_o (path_bus)
  );

  always #4 clk_i = ~clk_i;

  path_cmd_t   expected_cmds_q [$];
  string       pt_name [6] = '{"ctrl1_x", "ctrl1_y", "ctrl2_x", "ctrl2_y", "end_x", "end_y"};
  int          fail_count = 0;
  int          cmds_checked = 0;
  int          rects_sent = 0;
  int          n_rounded = 0;
  int          n_plain = 0;
  int          n_rejected = 0;
  int          sat_hits = 0;
  int          burst_left = 0;
  int          gap_max = 0;
  int          stall_mode = 0;
  int          idle_cycles = 0;
  logic [15:0] stall_pattern = 16'hffff;

  // ---------------------------------------------------------------- predictor

  function automatic coord_t clamp_coord(longint v);
    if (v > CoordHi) begin
      sat_hits++;
      return MaxC;
    end
    if (v < CoordLo) begin
      sat_hits++;
      return MinC;
    end
    return coord_t'(v);
  endfunction

  // radius times kappa, rounded half up back to Q16.16
  function automatic longint corner_offset(longint r);
    longint unsigned p;
    p = longint'(r) * KappaScale + 64'h8000_0000;
    return longint'(p >> 32);
  endfunction

  function automatic void add_cmd(cmd_e c, longint c1x, longint c1y, longint c2x,
                                  longint c2y, longint ex, longint ey, logic fin);
    path_cmd_t e;
    e.command = c;
    e.pt[0] = clamp_coord(c1x);
    e.pt[1] = clamp_coord(c1y);
    e.pt[2] = clamp_coord(c2x);
    e.pt[3] = clamp_coord(c2y);
    e.pt[4] = clamp_coord(ex);
    e.pt[5] = clamp_coord(ey);
    e.last = fin;
    expected_cmds_q.push_back(e);
  endfunction

  function automatic void predict_path_cmds(rect_t r);
    longint x, y, w, h, rx, ry, kx, ky;
    x = r.rect_x;
    y = r.rect_y;
    w = r.rect_width;
    h = r.rect_height;
    rx = r.radius_x_given ? longint'(r.radius_x) : 64'sd0;
    ry = r.radius_y_given ? longint'(r.radius_y) : 64'sd0;
    // a single given radius serves both axes
    if (r.radius_x_given && !r.radius_y_given) ry = rx;
    if (r.radius_y_given && !r.radius_x_given) rx = ry;

    if (w <= 0 || h <= 0) begin
      n_rejected++;
      add_cmd(CMD_REJECT, 0, 0, 0, 0, 0, 0, 1'b1);
      return;
    end

    if (rx > (w >>> 1)) rx = w >>> 1;
    if (ry > (h >>> 1)) ry = h >>> 1;

    if (rx <= 0 || ry <= 0) begin
      n_plain++;
      add_cmd(CMD_MOVE, 0, 0, 0, 0, x, y, 1'b0);
      add_cmd(CMD_LINE, 0, 0, 0, 0, x + w, y, 1'b0);
      add_cmd(CMD_LINE, 0, 0, 0, 0, x + w, y + h, 1'b0);
      add_cmd(CMD_LINE, 0, 0, 0, 0, x, y + h, 1'b0);
      add_cmd(CMD_CLOSE, 0, 0, 0, 0, 0, 0, 1'b1);
      return;
    end

    n_rounded++;
    kx = corner_offset(rx);
    ky = corner_offset(ry);
    add_cmd(CMD_MOVE, 0, 0, 0, 0, x + rx, y, 1'b0);
    add_cmd(CMD_LINE, 0, 0, 0, 0, x + w - rx, y, 1'b0);
    add_cmd(CMD_CURVE, x + w - rx + kx, y, x + w, y + ry - ky, x + w, y + ry, 1'b0);
    add_cmd(CMD_LINE, 0, 0, 0, 0, x + w, y + h - ry, 1'b0);
    add_cmd(CMD_CURVE, x + w, y + h - ry + ky, x + w - rx + kx, y + h,
            x + w - rx, y + h, 1'b0);
    add_cmd(CMD_LINE, 0, 0, 0, 0, x + rx, y + h, 1'b0);
    add_cmd(CMD_CURVE, x + rx - kx, y + h, x, y + h - ry + ky, x, y + h - ry, 1'b0);
    add_cmd(CMD_LINE, 0, 0, 0, 0, x, y + ry, 1'b0);
    add_cmd(CMD_CURVE, x, y + ry - ky, x + rx - kx, y, x + rx, y, 1'b0);
    add_cmd(CMD_CLOSE, 0, 0, 0, 0, 0, 0, 1'b1);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_error(string msg);
    fail_count++;
    if (fail_count <= 40) $display("ERROR %0t: %s", $time, msg);
  endtask

  task automatic check_path_cmd();
    path_cmd_t got;
    path_cmd_t want;
    got.command = path_bus.command;
    got.pt[0] = path_bus.ctrl1_x;
    got.pt[1] = path_bus.ctrl1_y;
    got.pt[2] = path_bus.ctrl2_x;
    got.pt[3] = path_bus.ctrl2_y;
    got.pt[4] = path_bus.end_x;
    got.pt[5] = path_bus.end_y;
    got.last = path_bus.last;
    cmds_checked++;
    if (expected_cmds_q.size() == 0) begin
      report_error($sformatf("command %0d (code %0d) arrived with nothing expected",
                             cmds_checked, got.command));
      return;
    end
    want = expected_cmds_q.pop_front();
    if (got.command !== want.command)
      report_error($sformatf("command %0d: code got %0d want %0d",
                             cmds_checked, got.command, want.command));
    for (int i = 0; i < 6; i++) begin
      if (got.pt[i] !== want.pt[i])
        report_error($sformatf("command %0d: %s got %h want %h",
                               cmds_checked, pt_name[i], got.pt[i], want.pt[i]));
    end
    if (got.last !== want.last)
      report_error($sformatf("command %0d: last got %b want %b",
                             cmds_checked, got.last, want.last));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && path_bus.valid && path_bus.ready) check_path_cmd();
  end

  // no request accepted and no expected command consumed for too long means the
  // block hung; a stream of unexpected commands does not keep the run alive
  always @(posedge clk_i) begin
    if ((rect_bus.valid && rect_bus.ready) ||
        (path_bus.valid && path_bus.ready && expected_cmds_q.size() != 0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: nothing accepted for %0d cycles, %0d commands outstanding",
               idle_cycles, expected_cmds_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver

  function automatic logic [15:0] stall_word(int mode);
    if (mode == 2) return 16'($urandom & $urandom & $urandom) | 16'h0001;
    return 16'($urandom) | 16'h0001;
  endfunction

  always @(negedge clk_i) begin
    if (stall_mode == 0) begin
      path_bus.ready <= 1'b1;
    end else begin
      path_bus.ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      if ($urandom_range(0, 63) == 0) stall_pattern = stall_word(stall_mode);
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic set_idle(int gap, int stall);
    gap_max = gap;
    stall_mode = stall;
    stall_pattern = stall_word(stall);
  endtask

  task automatic send_rect(rect_t r);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        rect_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    rect_bus.rect_x         <= r.rect_x;
    rect_bus.rect_y         <= r.rect_y;
    rect_bus.rect_width     <= r.rect_width;
    rect_bus.rect_height    <= r.rect_height;
    rect_bus.radius_x       <= r.radius_x;
    rect_bus.radius_y       <= r.radius_y;
    rect_bus.radius_x_given <= r.radius_x_given;
    rect_bus.radius_y_given <= r.radius_y_given;
    rect_bus.valid          <= 1'b1;
    do @(posedge clk_i); while (!rect_bus.ready);
    rects_sent++;
    predict_path_cmds(r);
  endtask

  task automatic wait_path_drained();
    @(negedge clk_i);
    rect_bus.valid <= 1'b0;
    burst_left = 0;
    while (expected_cmds_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic rect_t make_rect(coord_t x, coord_t y, coord_t w, coord_t h,
                                      coord_t rx, coord_t ry, logic gx, logic gy);
    rect_t r;
    r.rect_x = x;
    r.rect_y = y;
    r.rect_width = w;
    r.rect_height = h;
    r.radius_x = rx;
    r.radius_y = ry;
    r.radius_x_given = gx;
    r.radius_y_given = gy;
    return r;
  endfunction

  // ---------------------------------------------------------------- random fields

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return coord_t'($urandom);
      1: return MaxC - coord_t'($urandom_range(0, 32'h0001_ffff));
      2: return MinC + coord_t'($urandom_range(0, 32'h0001_ffff));
      default: return coord_t'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic coord_t pick_side(bit noisy);
    int sel;
    sel = $urandom_range(0, noisy ? 7 : 19);
    case (sel)
      0: return '0;
      1: return -coord_t'($urandom_range(1, 32'h000f_ffff));
      2: return coord_t'($urandom);
      3: return MaxC - coord_t'($urandom_range(0, 32'h0000_ffff));
      4: return coord_t'($urandom_range(1, 5));
      default: return coord_t'($urandom_range(1, 32'h00ff_ffff));
    endcase
  endfunction

  function automatic coord_t pick_radius(coord_t side);
    logic [31:0] lim;
    lim = (side > 1) ? 32'(side >>> 1) : 32'd1;
    case ($urandom_range(0, 11))
      0: return coord_t'($urandom);
      1: return '0;
      2: return -coord_t'($urandom_range(1, 32'h0003_ffff));
      3: return (side > 0) ? side : MaxC;
      4: return coord_t'($urandom_range(1, 3));
      default: return coord_t'($urandom_range(1, lim));
    endcase
  endfunction

  function automatic rect_t pick_rect(bit noisy);
    rect_t r;
    r.rect_x = pick_coord();
    r.rect_y = pick_coord();
    r.rect_width = pick_side(noisy);
    r.rect_height = pick_side(noisy);
    r.radius_x = noisy ? coord_t'($urandom) : pick_radius(r.rect_width);
    r.radius_y = noisy ? coord_t'($urandom) : pick_radius(r.rect_height);
    if (noisy) begin
      {r.radius_x_given, r.radius_y_given} = 2'($urandom);
    end else begin
      // mostly both radii present, so the corner arcs get exercised
      case ($urandom_range(0, 9))
        0: {r.radius_x_given, r.radius_y_given} = 2'b00;
        1: {r.radius_x_given, r.radius_y_given} = 2'b10;
        2: {r.radius_x_given, r.radius_y_given} = 2'b01;
        default: {r.radius_x_given, r.radius_y_given} = 2'b11;
      endcase
    end
    return r;
  endfunction

  task automatic pick_idle_mode();
    int gaps [3] = '{0, 2, 8};
    set_idle(gaps[$urandom_range(0, 2)], $urandom_range(0, 2));
  endtask

  // ---------------------------------------------------------------- tests

  // non-positive sizes, sent back to back with no stalls
  task automatic test_reject_cases();
    set_idle(0, 0);
    send_rect(make_rect(Q1, Q1, '0, 4 * Q1, Q1, Q1, 1'b1, 1'b1));
    send_rect(make_rect('0, '0, 4 * Q1, '0, '0, '0, 1'b0, 1'b0));
    send_rect(make_rect(-Q1, Q1, -32'sd1, Q1, Q1, '0, 1'b1, 1'b0));
    send_rect(make_rect(MaxC, MinC, MinC, MinC, MaxC, MaxC, 1'b1, 1'b1));
    send_rect(make_rect('0, '0, MaxC, -Q1, MinC, MinC, 1'b1, 1'b1));
    wait_path_drained();
  endtask

  // which radius is used when one, both or neither is present
  task automatic test_radius_selection();
    set_idle(3, 1);
    send_rect(make_rect('0, '0, 4 * Q1, 2 * Q1, MaxC, MaxC, 1'b0, 1'b0));
    send_rect(make_rect(Q1, 2 * Q1, 8 * Q1, 6 * Q1, Q1, MinC, 1'b1, 1'b0));
    send_rect(make_rect(-3 * Q1, -Q1, 8 * Q1, 6 * Q1, MaxC, Q1 >>> 1, 1'b0, 1'b1));
    send_rect(make_rect('0, '0, 10 * Q1, 4 * Q1, 2 * Q1, Q1, 1'b1, 1'b1));
    send_rect(make_rect('0, '0, 10 * Q1, 4 * Q1, '0, Q1, 1'b1, 1'b1));
    send_rect(make_rect('0, '0, 10 * Q1, 4 * Q1, Q1, -Q1, 1'b1, 1'b1));
    send_rect(make_rect('0, '0, 10 * Q1, 4 * Q1, -Q1, 2 * Q1, 1'b1, 1'b0));
    send_rect(make_rect(Q1, Q1, 10 * Q1, 4 * Q1, MinC, MaxC, 1'b1, 1'b1));
    wait_path_drained();
  endtask

  // radius clamped to half the side, tiny shapes, kappa rounding, edge saturation
  task automatic test_clamp_and_saturation();
    set_idle(2, 2);
    send_rect(make_rect('0, '0, 32'sh0003_0001, 32'sh0002_0003, MaxC, MaxC, 1'b1, 1'b1));
    send_rect(make_rect(32'sd5, 32'sd7, 32'sd2, 32'sd2, 32'sd1, 32'sd1, 1'b1, 1'b1));
    send_rect(make_rect('0, '0, 32'sd3, 32'sd5, MaxC, MaxC, 1'b1, 1'b1));
    send_rect(make_rect(MinC, MaxC, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 1'b1, 1'b1));
    send_rect(make_rect(MaxC, MaxC, MaxC, MaxC, MaxC, MaxC, 1'b1, 1'b1));
    send_rect(make_rect(MinC, MinC, MaxC, MaxC, MaxC, MaxC, 1'b1, 1'b1));
    send_rect(make_rect(MaxC - Q1, '0, 2 * Q1, MaxC, '0, '0, 1'b0, 1'b0));
    send_rect(make_rect('0, '0, 64 * Q1, 64 * Q1, 32'sd3, 32'sh0001_8001, 1'b1, 1'b1));
    wait_path_drained();
  endtask

  // mostly well-formed rectangles with random content, idle mode picked anew every chunk after the first
  task automatic test_random_rounded(int chunks);
    for (int c = 0; c < chunks; c++) begin
      if (c == 0) set_idle(0, 0);
      else pick_idle_mode();
      repeat (25) send_rect(pick_rect(1'b0));
    end
    wait_path_drained();
  endtask

  // random fields and flags, many rejects and ignored radii
  task automatic test_random_noise(int chunks);
    for (int c = 0; c < chunks; c++) begin
      pick_idle_mode();
      repeat (26) send_rect(pick_rect(1'b1));
    end
    wait_path_drained();
  endtask

  initial begin
    rect_bus.valid = 1'b0;
    rect_bus.rect_x = '0;
    rect_bus.rect_y = '0;
    rect_bus.rect_width = '0;
    rect_bus.rect_height = '0;
    rect_bus.radius_x = '0;
    rect_bus.radius_y = '0;
    rect_bus.radius_x_given = 1'b0;
    rect_bus.radius_y_given = 1'b0;
    path_bus.ready = 1'b0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reject_cases();
    test_radius_selection();
    test_clamp_and_saturation();
    test_random_rounded(10);
    test_random_noise(5);

    repeat (TailCycles) @(posedge clk_i);
    if (expected_cmds_q.size() != 0)
      report_error($sformatf("%0d commands never arrived", expected_cmds_q.size()));

    $display("covered %0d rectangles: %0d rounded, %0d plain, %0d rejected",
             rects_sent, n_rounded, n_plain, n_rejected);
    $display("checked %0d path commands, %0d saturated coordinates, %0d errors",
             cmds_checked, sat_hits, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rrp_pkg.sv
rtl/core/rrp_rect_if.sv
rtl/core/rrp_path_if.sv
rtl/core/rounded_rect_to_path.sv
rtl/core/rrp_checker.sv
sim/tb_top.sv
